// ===== src/bpcg_pkg.sv =====
// shared constants and types for the box plane contact generator
`default_nettype none
package bpcg_pkg;
   localparam int unsigned ContactCapacity = 256;
   localparam int unsigned CountWidth = $clog2(ContactCapacity + 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(ContactCapacity);
   localparam int unsigned SlotWidth = 8;
   localparam int unsigned CornerCount = 8;
   localparam int unsigned MatDepth = 32;
   localparam int unsigned MatAddrWidth = $clog2(MatDepth);
   localparam int unsigned CsrAddrWidth = 4;

   typedef enum logic [1:0] {
      OP_LOAD_BODY = 2'd0,
      OP_LOAD_PART = 2'd1,
      OP_EVALUATE  = 2'd2,
      OP_UNUSED    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_NORMAL_X = 2'd0,
      CSR_NORMAL_Y = 2'd1,
      CSR_NORMAL_Z = 2'd2,
      CSR_PLANE_D  = 2'd3
   } csr_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647) r = 32'sh7fffffff;
      else if (v < -34'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
      logic signed [33:0] s;
      s = 34'(a) + 34'(b);
      return sat32(s);
   endfunction

   function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
      logic signed [33:0] s;
      s = 34'(a) - 34'(b);
      return sat32(s);
   endfunction

   function automatic logic signed [31:0] qneg(input logic signed [31:0] a);
      logic signed [33:0] s;
      s = -34'(a);
      return sat32(s);
   endfunction

   // product shifted by 16 with floor, saturated
   function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
      logic signed [47:0] q;
      logic signed [31:0] r;
      q = p[63:16];
      if (q > 48'sd2147483647) r = 32'sh7fffffff;
      else if (q < -48'sd2147483648) r = 32'sh80000000;
      else r = q[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== src/bpcg_ram.sv =====
// generic ram with one write port and one registered read port
`default_nettype none
module bpcg_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] waddr,
   input  wire logic [Width-1:0]         wdata,
   input  wire logic [$clog2(Depth)-1:0] raddr,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== src/box_plane_contact_generator.sv =====
// box against half-space contact generator top level
`default_nettype none
// Usage: an input beat is taken at a rising edge with start high and busy low.
// Body rows (operation 0) and box offset rows (operation 1) are written to the
// matrix ram as four words in ST_LOAD, and the next beat is taken once the load ends.
// A load with row 3 and operation 3 are dropped with no result.
// An evaluate beat (operation 2) carries the half sizes and starts work.
// Matrices live in one ram of 32 words: body at 0..11, part at 16..27,
// composed rows 0 and 1 at 12..15 and 28..31, composed row 2 in registers.
// One shared 32x32 multiplier with a registered product does every multiply.
// Composition: 36 products, 3 translation adds and 12 writes. Each corner:
// 12 terms, 3 distance products and one output state. Each of the eight
// result beats is shown on rsp_valid, held for one cycle; the eighth comes
// in the first cycle with busy low, which ends the evaluate.
// The receiver cannot stall. Reset holds busy high and clears all 32 words of
// the matrix ram in a clearing pass after reset drops, sets the normal to +y
// and plane distance and contact counter to zero. The user must write the csr
// port only while idle; the block itself does not enforce this.
module box_plane_contact_generator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [1:0]  req_row,
   input  wire logic [31:0] req_value_a,
   input  wire logic [31:0] req_value_b,
   input  wire logic [31:0] req_value_c,
   input  wire logic [31:0] req_value_d,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [bpcg_pkg::CsrAddrWidth-1:0] paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output logic             rsp_valid,
   output logic [31:0]      rsp_point_x,
   output logic [31:0]      rsp_point_y,
   output logic [31:0]      rsp_point_z,
   output logic [31:0]      rsp_penetration,
   output logic             rsp_touching,
   output logic [7:0]       rsp_contact_slot,
   output logic             rsp_overflow,
   output logic             rsp_last
);
   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD, ST_RD, ST_MUL, ST_ACC, ST_TADD, ST_TWR,
      ST_CRD, ST_CMUL, ST_CACC, ST_DIST, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic signed [31:0] nx_ff, ny_ff, nz_ff, pd_ff;
   logic [bpcg_pkg::CountWidth-1:0] count_ff;
   logic [4:0] clr_ff;
   logic [31:0] va_ff, vb_ff, vc_ff, vd_ff;
   logic [4:0] base_ff;
   logic [1:0] ld_ff;
   // composition: r row, c column, j term
   logic [1:0] r_ff, c_ff, j_ff;
   logic [2:0] k_ff;
   logic signed [31:0] acc_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] w_ff [3];
   logic signed [31:0] dist_ff;
   logic [1:0] phase_ff; // 0 first operand read, 1 second operand read
   logic signed [31:0] aop_ff;

   logic we;
   logic [bpcg_pkg::MatAddrWidth-1:0] waddr, raddr;
   logic [31:0] wdata, rdata;

   bpcg_ram #(.Width(32), .Depth(bpcg_pkg::MatDepth)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   logic csr_wr;
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      case (bpcg_pkg::csr_type'(paddr[3:2]))
         bpcg_pkg::CSR_NORMAL_X: prdata = nx_ff;
         bpcg_pkg::CSR_NORMAL_Y: prdata = ny_ff;
         bpcg_pkg::CSR_NORMAL_Z: prdata = nz_ff;
         bpcg_pkg::CSR_PLANE_D:  prdata = pd_ff;
         default:                prdata = '0;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // t rows use addresses 12..15 (row0) and 28..31 (row1); row 2 maps onto
   // addresses 0..3 but is kept in registers instead: mapped below
   function automatic logic [4:0] t_addr(input logic [1:0] r, input logic [1:0] c);
      logic [4:0] a;
      case (r)
         2'd0:    a = 5'd12 + 5'(c);
         2'd1:    a = 5'd28 + 5'(c);
         default: a = {3'b0, c} + 5'd0; // row 2 maps onto body row 0 but is never written there
      endcase
      return a;
   endfunction

   // read address and second operand selection
   logic signed [31:0] corner_v;
   always_comb begin
      case (j_ff)
         2'd0:    corner_v = k_ff[2] ? bpcg_pkg::qneg(va_ff) : va_ff;
         2'd1:    corner_v = k_ff[1] ? bpcg_pkg::qneg(vb_ff) : vb_ff;
         default: corner_v = k_ff[0] ? bpcg_pkg::qneg(vc_ff) : vc_ff;
      endcase
   end

   always_comb begin
      raddr = '0;
      case (state_ff)
         ST_RD: begin
            if (phase_ff == 2'd0) raddr = {1'b0, r_ff, j_ff};
            else raddr = 5'd16 + {1'b0, j_ff, c_ff};
         end
         ST_ACC:  raddr = {1'b0, r_ff, 2'd3};
         ST_CRD:  raddr = t_addr(r_ff, (j_ff == 2'd3) ? 2'd3 : j_ff);
         default: raddr = '0;
      endcase
   end

   // row 2 of t must not overwrite body row 0 before row 2 is done:
   // rows are composed in order 0,1,2 and row 2 reads only body row 2
   always_comb begin
      we = 1'b0; waddr = '0; wdata = '0;
      case (state_ff)
         ST_CLEAR: begin we = 1'b1; waddr = clr_ff; end
         ST_LOAD: begin
            we = 1'b1; waddr = base_ff + {3'b0, ld_ff};
            case (ld_ff)
               2'd0: wdata = va_ff;
               2'd1: wdata = vb_ff;
               2'd2: wdata = vc_ff;
               default: wdata = vd_ff;
            endcase
         end
         ST_TWR: begin
            we = (r_ff != 2'd2);
            waddr = t_addr(r_ff, c_ff); wdata = acc_ff;
         end
         default: ;
      endcase
   end

   // row 2 of t is buffered here since body row 0 words are free only later
   logic signed [31:0] t2_ff [4];
   logic signed [31:0] tread;
   assign tread = (r_ff == 2'd2) ? t2_ff[j_ff] : rdata;

   logic signed [31:0] dot_a;
   always_comb begin
      case (r_ff)
         2'd0: dot_a = nx_ff;
         2'd1: dot_a = ny_ff;
         default: dot_a = nz_ff;
      endcase
   end

   // shared multiplier operands
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   always_comb begin
      case (state_ff)
         ST_MUL: begin
            mul_a = aop_ff; mul_b = rdata;
         end
         ST_CMUL: begin
            mul_a = tread; mul_b = corner_v;
         end
         default: begin
            mul_a = w_ff[r_ff]; mul_b = dot_a;
         end
      endcase
   end
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   logic contact;
   assign contact = dist_ff[31];

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      rsp_valid <= !reset && (state_ff == ST_OUT);
      if (reset) begin
         nx_ff <= '0; ny_ff <= 32'sd65536; nz_ff <= '0; pd_ff <= '0;
         count_ff <= '0; clr_ff <= '0;
      end else begin
         if (csr_wr) begin
            case (bpcg_pkg::csr_type'(paddr[3:2]))
               bpcg_pkg::CSR_NORMAL_X: nx_ff <= pwdata;
               bpcg_pkg::CSR_NORMAL_Y: ny_ff <= pwdata;
               bpcg_pkg::CSR_NORMAL_Z: nz_ff <= pwdata;
               bpcg_pkg::CSR_PLANE_D:  pd_ff <= pwdata;
               default: ;
            endcase
         end
         case (state_ff)
            ST_CLEAR: clr_ff <= clr_ff + 5'd1;
            ST_IDLE: begin
               va_ff <= req_value_a; vb_ff <= req_value_b;
               vc_ff <= req_value_c; vd_ff <= req_value_d;
               ld_ff <= '0;
               base_ff <= (req_operation == bpcg_pkg::OP_LOAD_PART ? 5'd16 : 5'd0)
                          + {1'b0, req_row, 2'd0};
               r_ff <= '0; c_ff <= '0; j_ff <= '0; phase_ff <= '0;
               acc_ff <= '0; k_ff <= '0;
            end
            ST_LOAD: ld_ff <= ld_ff + 2'd1;
            ST_RD: begin
               phase_ff <= phase_ff + 2'd1;
               if (phase_ff == 2'd1) aop_ff <= rdata;
            end
            ST_MUL: begin
               prod_ff <= mul_p;
               phase_ff <= '0;
            end
            ST_ACC: begin
               acc_ff <= bpcg_pkg::qadd(acc_ff, bpcg_pkg::qscale(prod_ff));
               j_ff <= j_ff + 2'd1;
            end
            // translation column add after the third product of column 3
            ST_TADD: acc_ff <= bpcg_pkg::qadd(acc_ff, rdata);
            ST_TWR: begin
               if (r_ff == 2'd2) t2_ff[c_ff] <= acc_ff;
               acc_ff <= '0; j_ff <= '0;
               if (c_ff == 2'd3) begin
                  c_ff <= '0;
                  r_ff <= (r_ff == 2'd2) ? 2'd0 : r_ff + 2'd1;
               end else c_ff <= c_ff + 2'd1;
            end
            ST_CRD: ;
            ST_CMUL: begin
               if (j_ff == 2'd3) acc_ff <= bpcg_pkg::qadd(acc_ff, tread);
               else prod_ff <= mul_p;
            end
            ST_CACC: begin
               if (j_ff == 2'd3) begin
                  w_ff[r_ff] <= acc_ff; acc_ff <= '0; j_ff <= '0;
                  r_ff <= (r_ff == 2'd2) ? 2'd0 : r_ff + 2'd1;
               end else begin
                  acc_ff <= bpcg_pkg::qadd(acc_ff, bpcg_pkg::qscale(prod_ff));
                  j_ff <= j_ff + 2'd1;
               end
            end
            ST_DIST: begin
               // three products of w and n then subtract, r counts terms
               if (phase_ff == 2'd0) begin
                  prod_ff <= mul_p;
                  phase_ff <= 2'd1;
               end else begin
                  phase_ff <= 2'd0;
                  if (r_ff == 2'd2) begin
                     dist_ff <= bpcg_pkg::qsub(
                        bpcg_pkg::qadd(acc_ff, bpcg_pkg::qscale(prod_ff)), pd_ff);
                     acc_ff <= '0; r_ff <= '0;
                  end else begin
                     acc_ff <= bpcg_pkg::qadd(acc_ff, bpcg_pkg::qscale(prod_ff));
                     r_ff <= r_ff + 2'd1;
                  end
               end
            end
            ST_OUT: begin
               rsp_point_x <= w_ff[0]; rsp_point_y <= w_ff[1];
               rsp_point_z <= w_ff[2]; rsp_penetration <= dist_ff;
               rsp_touching <= contact;
               if (contact && count_ff < bpcg_pkg::CountFull) begin
                  rsp_contact_slot <= count_ff[bpcg_pkg::SlotWidth-1:0];
                  rsp_overflow <= 1'b0;
                  count_ff <= count_ff + 1'b1;
               end else begin
                  rsp_contact_slot <= '0;
                  rsp_overflow <= contact;
               end
               rsp_last <= (k_ff == 3'd7);
               k_ff <= k_ff + 3'd1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      if (reset) state_in = ST_CLEAR;
      else begin
         case (state_ff)
            ST_CLEAR: if (clr_ff == 5'd31) state_in = ST_IDLE;
            ST_IDLE: if (start) begin
               case (bpcg_pkg::op_type'(req_operation))
                  bpcg_pkg::OP_LOAD_BODY, bpcg_pkg::OP_LOAD_PART:
                     if (req_row != 2'd3) state_in = ST_LOAD;
                  bpcg_pkg::OP_EVALUATE: state_in = ST_RD;
                  default: ;
               endcase
            end
            ST_LOAD: if (ld_ff == 2'd3) state_in = ST_IDLE;
            ST_RD: if (phase_ff == 2'd1) state_in = ST_MUL;
            ST_MUL: state_in = ST_ACC;
            ST_ACC: state_in = (j_ff == 2'd2) ? (c_ff == 2'd3 ? ST_TADD : ST_TWR) : ST_RD;
            ST_TADD: state_in = ST_TWR;
            ST_TWR: state_in = (c_ff == 2'd3 && r_ff == 2'd2) ? ST_CRD : ST_RD;
            ST_CRD: state_in = ST_CMUL;
            ST_CMUL: state_in = ST_CACC;
            ST_CACC: state_in = (j_ff == 2'd3 && r_ff == 2'd2) ? ST_DIST : ST_CRD;
            ST_DIST: if (phase_ff == 2'd1 && r_ff == 2'd2) state_in = ST_OUT;
            ST_OUT: state_in = (k_ff == 3'd7) ? ST_IDLE : ST_CRD;
            default: state_in = ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
